// ===== design/orbb_pkg.sv =====
package orbb_pkg;

  localparam int unsigned RingBytesDefault = 4096;
  localparam int unsigned CapWidth = 13;
  localparam logic [CapWidth-1:0] CapReset = 13'd4096;

  typedef enum logic [1:0] {
    StDone    = 2'd0,
    StFullEmp = 2'd1,
    StInvalid = 2'd2,
    StUnbound = 2'd3
  } status_e;

  typedef enum logic {
    ModeWrite = 1'b0,
    ModeRead  = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [63:0] offset;
    logic [63:0] ack_offset;
    logic [7:0]  data_byte;
    logic        request_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [63:0] new_offset;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    in_item_t item;
    logic     unbound;
    logic     win_ok;
  } cls_item_t;

endpackage

// ===== design/offset_ring_byte_buffer_top.sv =====
// From input acceptance to the output: a 64-step restoring divider forms offset modulo
// capacity, then a check state, a RAM read state for reads and an output state; an unbound
// item leaves the divider state at once and goes to the output state.
// The back end takes one item at a time and takes no new item until its output is accepted;
// a two-entry queue decouples the input.
// Asynchronous active-low reset clears offsets, pending state and control; capacity resets to 4096.
module offset_ring_byte_buffer_top #(
  parameter int unsigned RingBytes = orbb_pkg::RingBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  orbb_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output orbb_pkg::out_item_t           out_item_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [orbb_pkg::CapWidth-1:0] cfg_data_i
);
  import orbb_pkg::*;

  logic [CapWidth-1:0] cap_q;
  cls_item_t q_mem_q [2];
  logic      q_wp_q, q_rp_q;
  logic [1:0] q_cnt_q;
  logic      push, pop, back_idle;
  cls_item_t cls_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  orbb_front #(.RingBytes(RingBytes)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .item_i  (in_item_i),
    .cap_i   (cap_q),
    .q_full_i(q_cnt_q == 2'd2),
    .push_o  (push),
    .cls_o   (cls_in)
  );

  always_ff @(posedge clk_i) begin
    if (push) q_mem_q[q_wp_q] <= cls_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wp_q  <= 1'b0;
      q_rp_q  <= 1'b0;
      q_cnt_q <= 2'd0;
    end else begin
      if (push) q_wp_q <= ~q_wp_q;
      if (pop)  q_rp_q <= ~q_rp_q;
      q_cnt_q <= q_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  orbb_back #(.RingBytes(RingBytes)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_cnt_q != 2'd0),
    .pop_o    (pop),
    .cls_i    (q_mem_q[q_rp_q]),
    .cap_i    (cap_q),
    .valid_o  (out_valid_o),
    .stall_i  (out_stall_i),
    .item_o   (out_item_o),
    .idle_o   (back_idle)
  );

  logic unused_idle;
  assign unused_idle = back_idle;

  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) q_cnt_q <= 2'd2)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_cnt_q != 2'd0) else $error("pop from empty queue");
  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q == 2'd2 |-> !push) else $error("push into full queue");
endmodule

// ===== design/orbb_ram.sv =====
module orbb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/orbb_front.sv =====
module orbb_front #(
  parameter int unsigned RingBytes = orbb_pkg::RingBytesDefault
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    stall_o,
  input  orbb_pkg::in_item_t                      item_i,
  input  logic [orbb_pkg::CapWidth-1:0]           cap_i,
  input  logic                                    q_full_i,
  output logic                                    push_o,
  output orbb_pkg::cls_item_t                     cls_o
);
  import orbb_pkg::*;

  logic [63:0] diff;
  logic [CapWidth-1:0] cap_eff;

  // A capacity above the ring size is taken as the ring size.
  assign cap_eff = (32'(cap_i) > 32'(RingBytes)) ? CapWidth'(RingBytes) : cap_i;

  // Reads are checked later against the published offset, so only writes
  // get their window checked here.
  assign diff    = item_i.offset - item_i.ack_offset;
  assign stall_o = q_full_i;
  assign push_o  = valid_i && !q_full_i;

  always_comb begin
    cls_o.item    = item_i;
    cls_o.unbound = (cap_i == '0);
    cls_o.win_ok  = (item_i.offset >= item_i.ack_offset) &&
                    (diff <= {{(64-CapWidth){1'b0}}, cap_eff});
  end

  logic unused_clk;
  assign unused_clk = clk_i ^ rst_ni;
endmodule

// ===== design/orbb_back.sv =====
module orbb_back #(
  parameter int unsigned RingBytes = orbb_pkg::RingBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          pop_o,
  input  orbb_pkg::cls_item_t           cls_i,
  input  logic [orbb_pkg::CapWidth-1:0] cap_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output orbb_pkg::out_item_t           item_o,
  output logic                          idle_o
);
  import orbb_pkg::*;

  localparam int unsigned AW = $clog2(RingBytes);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SDiv   = 5'b00010,
    SExec  = 5'b00100,
    SRead  = 5'b01000,
    SOut   = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  cls_item_t   cur_q;
  logic [63:0] pub_q, pend_q;
  logic        pend_v_q;
  logic [63:0] quo_q;
  logic [CapWidth:0] rem_q;
  logic [6:0]  cnt_q;
  logic [CapWidth-1:0] capv_q;
  out_item_t   out_q;
  logic        status_ok_q;

  logic [CapWidth-1:0] cap_eff;
  assign cap_eff = (32'(cap_i) > 32'(RingBytes)) ? CapWidth'(RingBytes) : cap_i;

  // Restoring divider: one quotient bit per cycle, only the remainder is kept.
  logic [CapWidth:0] rem_sh;
  assign rem_sh = {rem_q[CapWidth-1:0], quo_q[63]};

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_rdata;

  assign ram_addr = AW'(rem_q);

  orbb_ram #(.Width(8), .Depth(RingBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i(cur_q.item.data_byte),
    .raddr_i(ram_addr),
    .rdata_o(ram_rdata)
  );

  logic is_wr, rd_ok, wr_free;
  assign is_wr   = (cur_q.item.mode == ModeWrite);
  assign rd_ok   = (pub_q >= cur_q.item.offset) &&
                   ((pub_q - cur_q.item.offset) <= {{(64-CapWidth){1'b0}}, capv_q});
  assign wr_free = (cur_q.item.offset - cur_q.item.ack_offset) !=
                   {{(64-CapWidth){1'b0}}, capv_q};
  assign ram_we  = (state_q == SExec) && is_wr && cur_q.win_ok && wr_free;

  assign pop_o   = (state_q == SIdle) && q_valid_i;
  assign valid_o = (state_q == SOut);
  assign item_o  = out_q;
  assign idle_o  = (state_q == SIdle) && !q_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: if (q_valid_i) state_d = SDiv;
      SDiv:  if (cur_q.unbound) state_d = SOut;
             else if (cnt_q == 7'd64) state_d = SExec;
      SExec: state_d = (!is_wr && rd_ok && (cur_q.item.offset != pub_q)) ? SRead : SOut;
      SRead: state_d = SOut;
      SOut:  if (!stall_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      pub_q    <= '0;
      pend_q   <= '0;
      pend_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == SExec && is_wr) begin
        if (ram_we) begin
          if (cur_q.item.request_last) begin
            pub_q    <= cur_q.item.offset + 64'd1;
            pend_v_q <= 1'b0;
          end else begin
            pend_q   <= cur_q.item.offset + 64'd1;
            pend_v_q <= 1'b1;
          end
        end else if (pend_v_q) begin
          pub_q    <= pend_q;
          pend_v_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        cur_q  <= cls_i;
        capv_q <= cap_eff;
        quo_q  <= cls_i.item.offset;
        rem_q  <= '0;
        cnt_q  <= '0;
        out_q.status     <= StUnbound;
        out_q.read_byte  <= '0;
        out_q.new_offset <= cls_i.item.offset;
      end
      SDiv: begin
        if (cnt_q != 7'd64) begin
          quo_q <= {quo_q[62:0], 1'b0};
          rem_q <= (rem_sh >= {1'b0, capv_q}) ? rem_sh - {1'b0, capv_q} : rem_sh;
          cnt_q <= cnt_q + 7'd1;
        end
      end
      SExec: begin
        status_ok_q <= 1'b0;
        if (is_wr) begin
          if (!cur_q.win_ok) out_q.status <= StInvalid;
          else if (!wr_free) out_q.status <= StFullEmp;
          else begin
            out_q.status     <= StDone;
            out_q.new_offset <= cur_q.item.offset + 64'd1;
          end
        end else begin
          if (!rd_ok) out_q.status <= StInvalid;
          else if (cur_q.item.offset == pub_q) out_q.status <= StFullEmp;
          else begin
            out_q.status     <= StDone;
            out_q.new_offset <= cur_q.item.offset + 64'd1;
            status_ok_q      <= 1'b1;
          end
        end
      end
      SRead: out_q.read_byte <= ram_rdata;
      SOut: ;
      default: ;
    endcase
  end

  logic unused_ok;
  assign unused_ok = status_ok_q;
endmodule
